// File: design/pair_arith_gcd_ratio_macros.svh
// Assertion macros used by the gcd/ratio design file.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef PAIR_ARITH_GCD_RATIO_MACROS_SVH
`define PAIR_ARITH_GCD_RATIO_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define PAG_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pair_arith_gcd_ratio: implication check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define PAG_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pair_arith_gcd_ratio: next-cycle check failed");
`else
`define PAG_ASSERT_IMPL(name, ante, cons)
`define PAG_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: design/pag_pkg.sv
// Package for the gcd/ratio block: field widths, microcode word type and control ROM.
// Depends on nothing.
package pag_pkg;

   localparam int OPND_W  = 16;
   localparam int TOTAL_W = 17;
   localparam int PROD_W  = 32;
   localparam int SHIFT_W = 4;   // common power of two, at most 15 for a nonzero operand
   localparam int CNT_W   = 4;   // one division step per quotient bit
   localparam int STEP_W  = 4;
   localparam int OP_W    = 4;
   localparam int COND_W  = 3;

   // Datapath operations.
   localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD        = 4'd1;
   localparam logic [OP_W-1:0] OP_INIT        = 4'd2;
   localparam logic [OP_W-1:0] OP_HALVE_BOTH  = 4'd3;
   localparam logic [OP_W-1:0] OP_GCD_STEP    = 4'd4;
   localparam logic [OP_W-1:0] OP_SET_GCD     = 4'd5;
   localparam logic [OP_W-1:0] OP_DIV_STEP    = 4'd6;
   localparam logic [OP_W-1:0] OP_SAVE_HIGH   = 4'd7;
   localparam logic [OP_W-1:0] OP_SAVE_LOW    = 4'd8;
   localparam logic [OP_W-1:0] OP_CLEAR_RATIO = 4'd9;
   localparam logic [OP_W-1:0] OP_PRESENT     = 4'd10;

   // Jump conditions: when the condition holds the sequencer jumps, else it steps on.
   localparam logic [COND_W-1:0] CND_NEVER        = 3'd0;
   localparam logic [COND_W-1:0] CND_ALWAYS       = 3'd1;
   localparam logic [COND_W-1:0] CND_NO_REQ       = 3'd2;
   localparam logic [COND_W-1:0] CND_LO_ZERO      = 3'd3;
   localparam logic [COND_W-1:0] CND_BOTH_EVEN    = 3'd4;
   localparam logic [COND_W-1:0] CND_X_NONZERO    = 3'd5;
   localparam logic [COND_W-1:0] CND_CNT_NOT_LAST = 3'd6;
   localparam logic [COND_W-1:0] CND_OUT_FREE     = 3'd7;

   // Program steps.
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_INIT      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_HALVE     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_GCD       = 4'd3;
   localparam logic [STEP_W-1:0] STEP_SET_GCD   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIV_HIGH  = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SAVE_HIGH = 4'd6;
   localparam logic [STEP_W-1:0] STEP_DIV_LOW   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_SAVE_LOW  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_ZERO      = 4'd9;
   localparam logic [STEP_W-1:0] STEP_PRESENT   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_HOLD      = 4'd11;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // Control program, one word per step.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type word;
      case (step)
         STEP_IDLE:      word = '{OP_LOAD,        CND_NO_REQ,       STEP_IDLE};
         STEP_INIT:      word = '{OP_INIT,        CND_LO_ZERO,      STEP_ZERO};
         STEP_HALVE:     word = '{OP_HALVE_BOTH,  CND_BOTH_EVEN,    STEP_HALVE};
         STEP_GCD:       word = '{OP_GCD_STEP,    CND_X_NONZERO,    STEP_GCD};
         STEP_SET_GCD:   word = '{OP_SET_GCD,     CND_NEVER,        STEP_IDLE};
         STEP_DIV_HIGH:  word = '{OP_DIV_STEP,    CND_CNT_NOT_LAST, STEP_DIV_HIGH};
         STEP_SAVE_HIGH: word = '{OP_SAVE_HIGH,   CND_NEVER,        STEP_IDLE};
         STEP_DIV_LOW:   word = '{OP_DIV_STEP,    CND_CNT_NOT_LAST, STEP_DIV_LOW};
         STEP_SAVE_LOW:  word = '{OP_SAVE_LOW,    CND_ALWAYS,       STEP_PRESENT};
         STEP_ZERO:      word = '{OP_CLEAR_RATIO, CND_ALWAYS,       STEP_PRESENT};
         STEP_PRESENT:   word = '{OP_PRESENT,     CND_OUT_FREE,     STEP_IDLE};
         STEP_HOLD:      word = '{OP_NOP,         CND_ALWAYS,       STEP_PRESENT};
         default:        word = '{OP_NOP,         CND_ALWAYS,       STEP_IDLE};
      endcase
      return word;
   endfunction

endpackage

// File: design/pair_arith_gcd_ratio.sv
// One request at a time: the next is taken once the result is in the output register,
// so the rate is set by the gcd loop and the two 16-step restoring divisions, both of
// which are skipped when an operand is zero.
// Reset: synchronous, active high; clears the step counter and the result-valid flag.
// Uses pag_pkg and pair_arith_gcd_ratio_macros.svh.
`include "pair_arith_gcd_ratio_macros.svh"

module pair_arith_gcd_ratio
   import pag_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPND_W-1:0]   req_first_value,
   input  logic [OPND_W-1:0]   req_second_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OPND_W-1:0]   rsp_smaller,
   output logic [OPND_W-1:0]   rsp_larger,
   output logic [TOTAL_W-1:0]  rsp_total,
   output logic [OPND_W-1:0]   rsp_spread,
   output logic [PROD_W-1:0]   rsp_product,
   output logic [OPND_W-1:0]   rsp_common_divisor,
   output logic [OPND_W-1:0]   rsp_ratio_high,
   output logic [OPND_W-1:0]   rsp_ratio_low,
   output logic                rsp_ratio_valid
);

   // Sequencer state.
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ucode_type          uword;
   logic               cond_true;
   logic               accept;
   logic               out_free;
   logic               present_fire;
   logic               div_active;

   // Datapath registers.
   logic [OPND_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [OPND_W-1:0]  spread_ff, spread_in;
   logic [PROD_W-1:0]  product_ff, product_in;
   logic [OPND_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [SHIFT_W-1:0] k_ff, k_in;
   logic [OPND_W-1:0]  gcd_ff, gcd_in;
   logic [OPND_W-1:0]  quo_ff, quo_in;
   logic [OPND_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [OPND_W-1:0]  rh_ff, rh_in, rl_ff, rl_in;
   logic               valid_ff, valid_in;

   // Output registers.
   logic [OPND_W-1:0]  out_smaller_ff, out_larger_ff, out_spread_ff;
   logic [TOTAL_W-1:0] out_total_ff;
   logic [PROD_W-1:0]  out_product_ff;
   logic [OPND_W-1:0]  out_gcd_ff, out_rh_ff, out_rl_ff;
   logic               out_ratio_valid_ff;

   // Division step terms.
   logic [OPND_W:0]    rem_shift;
   logic [OPND_W+1:0]  rem_diff;

   // Request operand ordering.
   logic               first_lt;
   logic [OPND_W-1:0]  req_lo, req_hi;

   assign first_lt = req_first_value < req_second_value;
   assign req_lo   = first_lt ? req_first_value : req_second_value;
   assign req_hi   = first_lt ? req_second_value : req_first_value;

   // Handshake and control word fetch.
   assign uword        = ucode_rom(step_ff);
   assign req_stall    = step_ff != STEP_IDLE;
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign present_fire = (uword.op == OP_PRESENT) && out_free;
   assign div_active   = step_ff inside {STEP_DIV_HIGH, STEP_DIV_LOW};

   // Jump condition select.
   always_comb begin
      case (uword.cond)
         CND_NEVER:        cond_true = 1'b0;
         CND_ALWAYS:       cond_true = 1'b1;
         CND_NO_REQ:       cond_true = !accept;
         CND_LO_ZERO:      cond_true = lo_ff == '0;
         CND_BOTH_EVEN:    cond_true = !x_ff[0] && !y_ff[0];
         CND_X_NONZERO:    cond_true = x_ff != '0;
         CND_CNT_NOT_LAST: cond_true = cnt_ff != {CNT_W{1'b1}};
         CND_OUT_FREE:     cond_true = out_free;
         default:          cond_true = 1'b0;
      endcase
   end

   // Step counter: jump on a true condition, else advance.
   assign step_in = cond_true ? uword.target : step_ff + 1'b1;

   // Result valid flag, set when a result moves to the output register.
   assign rsp_valid_in = present_fire || (rsp_valid_ff && rsp_stall);

   // Restoring division: shift in the next dividend bit and try the subtraction.
   assign rem_shift = {rem_ff, quo_ff[OPND_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, gcd_ff};

   // Datapath, driven by the operation field of the control word.
   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      total_in   = total_ff;
      spread_in  = spread_ff;
      product_in = product_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      k_in       = k_ff;
      gcd_in     = gcd_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      rh_in      = rh_ff;
      rl_in      = rl_ff;
      valid_in   = valid_ff;
      case (uword.op)
         OP_LOAD: begin
            if (accept) begin
               lo_in      = req_lo;
               hi_in      = req_hi;
               total_in   = {1'b0, req_lo} + {1'b0, req_hi};
               spread_in  = req_hi - req_lo;
               product_in = {{(PROD_W-OPND_W){1'b0}}, req_lo}
                          * {{(PROD_W-OPND_W){1'b0}}, req_hi};
            end
         end
         OP_INIT: begin
            x_in = hi_ff;
            y_in = lo_ff;
            k_in = '0;
         end
         OP_HALVE_BOTH: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         OP_GCD_STEP: begin
            // Binary gcd: strip factors of two, else subtract the smaller odd value.
            if (x_ff != '0) begin
               if (!x_ff[0]) begin
                  x_in = x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_in = y_ff >> 1;
               end else if (x_ff >= y_ff) begin
                  x_in = x_ff - y_ff;
               end else begin
                  y_in = y_ff - x_ff;
               end
            end
         end
         OP_SET_GCD: begin
            gcd_in = y_ff << k_ff;
            quo_in = hi_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_DIV_STEP: begin
            if (!rem_diff[OPND_W+1]) begin
               rem_in = rem_diff[OPND_W-1:0];
               quo_in = {quo_ff[OPND_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift[OPND_W-1:0];
               quo_in = {quo_ff[OPND_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         OP_SAVE_HIGH: begin
            rh_in  = quo_ff;
            quo_in = lo_ff;
            rem_in = '0;
            cnt_in = '0;
         end
         OP_SAVE_LOW: begin
            rl_in    = quo_ff;
            valid_in = 1'b1;
         end
         OP_CLEAR_RATIO: begin
            gcd_in   = '0;
            rh_in    = '0;
            rl_in    = '0;
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      total_ff   <= total_in;
      spread_ff  <= spread_in;
      product_ff <= product_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      gcd_ff     <= gcd_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      rh_ff      <= rh_in;
      rl_ff      <= rl_in;
      valid_ff   <= valid_in;
      if (present_fire) begin
         out_smaller_ff     <= lo_ff;
         out_larger_ff      <= hi_ff;
         out_total_ff       <= total_ff;
         out_spread_ff      <= spread_ff;
         out_product_ff     <= product_ff;
         out_gcd_ff         <= gcd_ff;
         out_rh_ff          <= rh_ff;
         out_rl_ff          <= rl_ff;
         out_ratio_valid_ff <= valid_ff;
      end
   end

   // Result ports.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smaller        = out_smaller_ff;
   assign rsp_larger         = out_larger_ff;
   assign rsp_total          = out_total_ff;
   assign rsp_spread         = out_spread_ff;
   assign rsp_product        = out_product_ff;
   assign rsp_common_divisor = out_gcd_ff;
   assign rsp_ratio_high     = out_rh_ff;
   assign rsp_ratio_low      = out_rl_ff;
   assign rsp_ratio_valid    = out_ratio_valid_ff;

   // An accepted request always starts the gcd setup step next.
   `PAG_ASSERT_NEXT(a_accept_starts_init, accept, step_ff == STEP_INIT)
   // The gcd loop never loses its nonzero partner y.
   `PAG_ASSERT_IMPL(a_gcd_y_nonzero, step_ff == STEP_GCD, y_ff != '0)
   // The division remainder stays below the divisor.
   `PAG_ASSERT_IMPL(a_div_rem_bound, div_active, rem_ff < gcd_ff)
   // A valid ratio has a nonzero divisor and keeps the operand order.
   `PAG_ASSERT_IMPL(a_ratio_consistent, rsp_valid_ff && out_ratio_valid_ff,
                    out_gcd_ff != '0 && out_rh_ff >= out_rl_ff)
   // Without a valid ratio the divisor and ratio fields are zero.
   `PAG_ASSERT_IMPL(a_ratio_cleared, rsp_valid_ff && !out_ratio_valid_ff,
                    out_gcd_ff == '0 && out_rh_ff == '0 && out_rl_ff == '0)

endmodule

// File: dv/pair_arith_gcd_ratio_tb.sv
// Self-checking testbench for the pair_arith_gcd_ratio block: ordering, sum, difference,
// product, greatest common divisor and reduced ratio of operand pairs.
// Depends on pag_pkg and the pair_arith_gcd_ratio design files.
`timescale 1ns / 100ps

module testbench;
   import pag_pkg::*;

   // Everything the block reports for one operand pair.
   typedef struct packed {
      logic [OPND_W-1:0]  smaller;
      logic [OPND_W-1:0]  larger;
      logic [TOTAL_W-1:0] total;
      logic [OPND_W-1:0]  spread;
      logic [PROD_W-1:0]  product;
      logic [OPND_W-1:0]  common_divisor;
      logic [OPND_W-1:0]  ratio_high;
      logic [OPND_W-1:0]  ratio_low;
      logic               ratio_valid;
   } pair_result_type;

   typedef struct packed {
      logic [OPND_W-1:0] first;
      logic [OPND_W-1:0] second;
      pair_result_type   want;
   } awaited_pair_type;

   typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_BLOCKED} rx_mode_type;
   typedef enum logic [2:0] {
      ZERO_FIRST, ZERO_SECOND, BOTH_ZERO, EQUAL_PAIR, UNIT_PAIR, POWER_PAIR
   } degenerate_kind_type;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 160;
   localparam int unsigned MAX_PRINTED    = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OPND_W-1:0]  req_first_value = '0;
   logic [OPND_W-1:0]  req_second_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [OPND_W-1:0]  rsp_smaller;
   logic [OPND_W-1:0]  rsp_larger;
   logic [TOTAL_W-1:0] rsp_total;
   logic [OPND_W-1:0]  rsp_spread;
   logic [PROD_W-1:0]  rsp_product;
   logic [OPND_W-1:0]  rsp_common_divisor;
   logic [OPND_W-1:0]  rsp_ratio_high;
   logic [OPND_W-1:0]  rsp_ratio_low;
   logic               rsp_ratio_valid;

   awaited_pair_type awaited_results[$];
   int unsigned   error_count = 0;
   int unsigned   sent_count = 0;
   int unsigned   checked_count = 0;
   int unsigned   zero_count = 0;
   int unsigned   reduced_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   burst_left = 0;
   bit            steady_flow = 1'b0;
   rx_mode_type   rx_mode = RX_FREE;
   int unsigned   rx_left = 0;

   pair_arith_gcd_ratio dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_smaller        (rsp_smaller),
      .rsp_larger         (rsp_larger),
      .rsp_total          (rsp_total),
      .rsp_spread         (rsp_spread),
      .rsp_product        (rsp_product),
      .rsp_common_divisor (rsp_common_divisor),
      .rsp_ratio_high     (rsp_ratio_high),
      .rsp_ratio_low      (rsp_ratio_low),
      .rsp_ratio_valid    (rsp_ratio_valid)
   );

   // A 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Expected result of one pair; Euclid's remainder loop gives the divisor.
   function automatic pair_result_type predict_pair(input logic [OPND_W-1:0] a,
                                                    input logic [OPND_W-1:0] b);
      pair_result_type   r;
      logic [OPND_W-1:0] x;
      logic [OPND_W-1:0] y;
      logic [OPND_W-1:0] rem;
      r = '0;
      r.smaller = (a < b) ? a : b;
      r.larger  = (a < b) ? b : a;
      r.total   = {1'b0, r.smaller} + {1'b0, r.larger};
      r.spread  = r.larger - r.smaller;
      r.product = {{OPND_W{1'b0}}, r.smaller} * {{OPND_W{1'b0}}, r.larger};
      // With a zero operand the ratio fields stay cleared.
      if (r.smaller != '0) begin
         x = r.larger;
         y = r.smaller;
         while (y != '0) begin
            rem = x % y;
            x = y;
            y = rem;
         end
         r.common_divisor = x;
         r.ratio_high     = r.larger / x;
         r.ratio_low      = r.smaller / x;
         r.ratio_valid    = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [PROD_W-1:0] got,
                              input logic [PROD_W-1:0] want, input awaited_pair_type e);
      if (got !== want)
         report_mismatch($sformatf("%s is %0d, expected %0d, operands %0d and %0d",
                                   name, got, want, e.first, e.second));
   endtask

   // Present one request and hold it until the block takes it.
   task automatic send_pair(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
      awaited_pair_type e;
      req_valid        <= 1'b1;
      req_first_value  <= a;
      req_second_value <= b;
      do @(posedge clock); while (req_stall);
      e.first  = a;
      e.second = b;
      e.want   = predict_pair(a, b);
      awaited_results.push_back(e);
      sent_count++;
      if (!e.want.ratio_valid) zero_count++;
      else if (e.want.common_divisor > 1) reduced_count++;
   endtask

   // Sender in bursts: outside steady flow, a random gap with junk on the payload before each burst.
   task automatic issue_pair(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = steady_flow ? 0 : $urandom_range(0, 20);
         if (gap != 0) begin
            req_valid        <= 1'b0;
            req_first_value  <= OPND_W'($urandom);
            req_second_value <= OPND_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_pair(a, b);
   endtask

   // Hold off the sender until every outstanding result has been checked.
   task automatic wait_results_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // Field extremes, zero operands, equal operands and common powers of two.
   task automatic test_corner_pairs();
      issue_pair(16'd0, 16'd0);
      issue_pair(16'd0, 16'hFFFF);
      issue_pair(16'hFFFF, 16'd0);
      issue_pair(16'd0, 16'd1);
      issue_pair(16'd1, 16'd0);
      issue_pair(16'hFFFF, 16'hFFFF);
      issue_pair(16'd1, 16'd1);
      issue_pair(16'hFFFF, 16'd1);
      issue_pair(16'd1, 16'hFFFF);
      issue_pair(16'hFFFF, 16'hFFFE);
      issue_pair(16'h8000, 16'h8000);
      issue_pair(16'h8000, 16'h4000);
      issue_pair(16'hA000, 16'h2000);
      issue_pair(16'd12, 16'd18);
      issue_pair(16'd18, 16'd12);
      issue_pair(16'd7, 16'd7);
      issue_pair(16'hFFFE, 16'h8000);
      issue_pair(16'd65521, 16'd65519);
      issue_pair(16'hAAAA, 16'h5555);
      issue_pair(16'd46368, 16'd28657);
      issue_pair(16'hF000, 16'hFF00);
   endtask

   // Operands drawn across the full range.
   task automatic test_uniform_pairs();
      repeat (300) issue_pair(OPND_W'($urandom), OPND_W'($urandom));
   endtask

   // Pairs built on a common factor, often a power of two.
   task automatic test_shared_factors();
      int unsigned g;
      repeat (250) begin
         if ($urandom_range(0, 1) != 0) g = 1 << $urandom_range(1, 14);
         else g = $urandom_range(2, 300);
         issue_pair(OPND_W'(g * $urandom_range(1, 65535 / g)),
                    OPND_W'(g * $urandom_range(1, 65535 / g)));
      end
   endtask

   // Zero operands, equal operands, a unit operand and pairs of powers of two.
   task automatic test_degenerate_pairs();
      degenerate_kind_type kind;
      logic [OPND_W-1:0]   v;
      repeat (150) begin
         kind = degenerate_kind_type'($urandom_range(0, 5));
         v = OPND_W'($urandom);
         case (kind)
            ZERO_FIRST:  issue_pair('0, v);
            ZERO_SECOND: issue_pair(v, '0);
            BOTH_ZERO:   issue_pair('0, '0);
            EQUAL_PAIR:  issue_pair(v, v);
            UNIT_PAIR: begin
               if ($urandom_range(0, 1) != 0) issue_pair(16'd1, v);
               else issue_pair(v, 16'd1);
            end
            default: issue_pair(16'h1 << $urandom_range(0, 15),
                                16'h1 << $urandom_range(0, 15));
         endcase
      end
   endtask

   // Requests offered without sender gaps, small operands first and then full-range ones.
   task automatic test_back_to_back();
      steady_flow = 1'b1;
      repeat (65) issue_pair(OPND_W'($urandom_range(0, 15)), OPND_W'($urandom_range(0, 15)));
      wait_results_drained();
      repeat (65) issue_pair(OPND_W'($urandom), OPND_W'($urandom));
      steady_flow = 1'b0;
   endtask

   // Receiver stall pattern: free, choppy or mostly blocked stretches.
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(32, 200);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_FREE:   rsp_stall <= 1'b0;
         RX_CHOPPY: rsp_stall <= ($urandom_range(0, 1) != 0);
         default:   rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare every accepted result with the oldest outstanding expectation.
   always @(posedge clock) begin
      awaited_pair_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result arrived with no request outstanding");
         end else begin
            e = awaited_results.pop_front();
            checked_count++;
            check_field("smaller", PROD_W'(rsp_smaller), PROD_W'(e.want.smaller), e);
            check_field("larger", PROD_W'(rsp_larger), PROD_W'(e.want.larger), e);
            check_field("total", PROD_W'(rsp_total), PROD_W'(e.want.total), e);
            check_field("spread", PROD_W'(rsp_spread), PROD_W'(e.want.spread), e);
            check_field("product", rsp_product, e.want.product, e);
            check_field("common_divisor", PROD_W'(rsp_common_divisor),
                        PROD_W'(e.want.common_divisor), e);
            check_field("ratio_high", PROD_W'(rsp_ratio_high),
                        PROD_W'(e.want.ratio_high), e);
            check_field("ratio_low", PROD_W'(rsp_ratio_low),
                        PROD_W'(e.want.ratio_low), e);
            check_field("ratio_valid", PROD_W'(rsp_ratio_valid),
                        PROD_W'(e.want.ratio_valid), e);
         end
      end
   end

   // Count cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[pair_arith_gcd_ratio] ERROR");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_pairs();
      wait_results_drained();
      test_uniform_pairs();
      test_shared_factors();
      wait_results_drained();
      test_degenerate_pairs();
      test_back_to_back();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d operand pairs and checked %0d results.", sent_count, checked_count);
      $display("Of these, %0d had a zero operand and %0d a common divisor above one.",
               zero_count, reduced_count);
      if (error_count == 0)
         $display("[pair_arith_gcd_ratio] OK");
      else
         $display("[pair_arith_gcd_ratio] ERROR");
      $finish;
   end

endmodule
